@@ hdl/psts_pkg.sv @@
// Package for the per-source traffic monitor: widths, table size, item and cell types.
// No dependencies.
package psts_pkg;

  localparam int MAX_SOURCES = 64;
  localparam int IDX_W       = $clog2(MAX_SOURCES);
  localparam int CNT_W       = $clog2(MAX_SOURCES + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WARM_UP      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_OFFSET = 1'd1;

  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  localparam logic [47:0] SAT48 = {48{1'b1}};
  localparam logic [31:0] SAT32 = {32{1'b1}};

  typedef struct packed {
    logic        func;
    logic [31:0] arrival_cycle;
    logic [9:0]  source_node;
    logic        is_head;
    logic [31:0] send_stamp;
  } in_item_t;

  typedef struct packed {
    logic        entry_hit;
    logic        dropped;
    logic [31:0] flit_count;
    logic [31:0] packet_count;
    logic [47:0] delay_total;
    logic [39:0] mean_delay_q8;
    logic [23:0] rate_q16;
    logic [31:0] all_flits;
    logic [31:0] all_packets;
    logic [6:0]  sources_seen;
    logic [39:0] all_mean_delay_q8;
    logic        div_by_zero;
  } out_item_t;

  // Per-source figures held in one cell.
  typedef struct packed {
    logic        valid;
    logic [9:0]  source;
    logic [31:0] flits;
    logic [31:0] packets;
    logic [47:0] delay_sum;
    logic [31:0] last_arrival;
  } entry_t;

  // Search token passed down the cell chain.
  typedef struct packed {
    logic        active;
    logic        update;
    logic [9:0]  source;
    logic        is_head;
    logic [31:0] delay;
    logic [31:0] last_arrival;
    logic        found;
    entry_t      hit;
  } probe_t;

  function automatic logic [31:0] inc_sat32(input logic [31:0] v);
    return (v == SAT32) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] add_sat48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? SAT48 : s[47:0];
  endfunction

endpackage

@@ hdl/psts_if.sv @@
// Valid/ready channel carrying one item of a given payload type.
// The payload type comes in as a parameter; no dependencies.
interface psts_if #(parameter type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/psts_cell.sv @@
// One table entry cell: compares the passing probe, updates or allocates itself.
// Depends on psts_pkg.
module psts_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  psts_pkg::probe_t   probe_in,
  input  logic               alloc,
  output psts_pkg::probe_t   probe_out
);
  import psts_pkg::*;

  entry_t ent_r, ent_nxt;
  probe_t prb_r, prb_nxt;
  logic   match;

  assign match = probe_in.active && ent_r.valid && (ent_r.source == probe_in.source);

  // Update own entry on hit or allocation; forward probe with captured figures.
  always_comb begin
    ent_nxt = ent_r;
    prb_nxt = probe_in;
    if (probe_in.active && probe_in.update && (match || alloc)) begin
      if (alloc) begin
        ent_nxt = '0;
        ent_nxt.valid  = 1'b1;
        ent_nxt.source = probe_in.source;
      end
      ent_nxt.flits = inc_sat32(alloc ? 32'd0 : ent_r.flits);
      if (probe_in.is_head) begin
        ent_nxt.packets   = inc_sat32(alloc ? 32'd0 : ent_r.packets);
        ent_nxt.delay_sum = add_sat48(alloc ? 48'd0 : ent_r.delay_sum, probe_in.delay);
      end
      ent_nxt.last_arrival = probe_in.last_arrival;
    end
    if (match || (alloc && probe_in.active && probe_in.update)) begin
      prb_nxt.found = 1'b1;
      prb_nxt.hit   = ent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
      prb_r <= '0;
    end else begin
      ent_r <= ent_nxt;
      prb_r <= prb_nxt;
    end
  end

  assign probe_out = prb_r;
endmodule

@@ hdl/psts_div.sv @@
// Restoring serial divider: floor(num / den), one quotient bit per cycle.
// Depends on psts_pkg.
module psts_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [55:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [55:0] quo
);
  import psts_pkg::*;

  logic [55:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] den_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;

  // Shift in one numerator bit and try a subtract.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], q_r[55]};
    if (start) begin
      q_nxt    = num;
      rem_nxt  = '0;
      cnt_nxt  = 6'd55;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt   = {q_r[54:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[54:0], 1'b0};
      end
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) den_r <= den;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

@@ hdl/per_source_traffic_stats.sv @@
// Per-source traffic monitor, top level: cell chain of MAX_SOURCES entries plus a divider.
// An accepted item walks the cell chain, then runs three serial divisions, then loads the result.
// One item in flight: the next item is taken only once the previous result is loaded,
// later if the result side stalls. The wait comes from the chain walk and the serial divider.
// Synchronous active-low reset clears the table, totals and config registers.
module per_source_traffic_stats (
  input  logic                                clk,
  input  logic                                rst_n,
  psts_if.sink                                in_ch,
  psts_if.source                              out_ch,
  input  logic                                cfg_we,
  input  logic [psts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psts_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import psts_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_WALK = 6'b000010, S_DIV0 = 6'b000100,
    S_DIV1 = 6'b001000, S_DIV2 = 6'b010000, S_OUT  = 6'b100000
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] warm_r, offs_r;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [31:0] gfl_r, gfl_nxt, gpk_r, gpk_nxt;
  logic [47:0] gds_r, gds_nxt;
  in_item_t    it_r;
  logic        drop_r, upd_r;
  logic [CNT_W-1:0] walk_r, walk_nxt;
  out_item_t   res_r;
  logic        ovld_r;
  entry_t      hit_r;
  logic        dz_r;
  logic        alloc_seen_r;
  logic [MAX_SOURCES-1:0] alloc_v;

  probe_t probe [MAX_SOURCES+1];
  probe_t head_probe;

  logic        div_start, div_done;
  logic [55:0] div_num, div_quo;
  logic [31:0] div_den;

  // Record qualification on the incoming item.
  logic [32:0] since;
  logic        warm_drop, accept;
  assign since     = {1'b0, in_ch.data.arrival_cycle} - {1'b0, offs_r};
  assign warm_drop = since[32] || (since[31:0] < warm_r);
  assign accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE) && !(ovld_r && !out_ch.ready);

  // Launch probe into the chain on accept.
  always_comb begin
    head_probe = '0;
    head_probe.active  = accept;
    head_probe.update  = (in_ch.data.func == FUNC_RECORD) && !warm_drop;
    head_probe.source  = in_ch.data.source_node;
    head_probe.is_head = in_ch.data.is_head;
    head_probe.delay   = (in_ch.data.arrival_cycle >= in_ch.data.send_stamp) ?
                         in_ch.data.arrival_cycle - in_ch.data.send_stamp : 32'd0;
    head_probe.last_arrival = in_ch.data.arrival_cycle - warm_r;
  end
  assign probe[0] = head_probe;

  // Allocate a new source in the cell at the fill count; cells fill in order, so any
  // existing entry lies below it and has already marked the probe as found.
  genvar g;
  generate
    for (g = 0; g < MAX_SOURCES; g++) begin : g_cell
      assign alloc_v[g] = probe[g].active && probe[g].update && !probe[g].found &&
                          (used_r == CNT_W'(g));
      psts_cell u_cell (
        .clk(clk), .rst_n(rst_n), .probe_in(probe[g]), .alloc(alloc_v[g]),
        .probe_out(probe[g+1])
      );
    end
  endgenerate

  psts_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // Operands per division phase.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state_r)
      S_WALK: begin
        div_start = (walk_r == '0);
        div_num   = {gds_nxt, 8'd0};
        div_den   = gpk_nxt;
      end
      S_DIV0: begin
        div_start = div_done;
        div_num   = {hit_r.delay_sum, 8'd0};
        div_den   = hit_r.packets;
      end
      S_DIV1: begin
        div_start = div_done;
        div_num   = {8'd0, hit_r.flits, 16'd0};
        div_den   = hit_r.last_arrival;
      end
      default: ;
    endcase
  end

  // Sequencer and totals.
  logic        rec_ok;
  assign rec_ok = probe[MAX_SOURCES].active && probe[MAX_SOURCES].found && upd_r;
  always_comb begin
    state_nxt = state_r;
    walk_nxt  = walk_r;
    used_nxt  = used_r;
    gfl_nxt   = gfl_r;
    gpk_nxt   = gpk_r;
    gds_nxt   = gds_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_WALK;
          walk_nxt  = CNT_W'(MAX_SOURCES);
        end
      end
      S_WALK: begin
        if (walk_r == '0) begin
          state_nxt = S_DIV0;
        end else begin
          walk_nxt = walk_r - CNT_W'(1);
          if (walk_r == CNT_W'(1) && rec_ok) begin
            gfl_nxt = inc_sat32(gfl_r);
            if (it_r.is_head) begin
              gpk_nxt = inc_sat32(gpk_r);
              gds_nxt = add_sat48(gds_r, probe[MAX_SOURCES].delay);
            end
            if (alloc_seen_r) used_nxt = used_r + CNT_W'(1);
          end
        end
      end
      S_DIV0:  if (div_done) state_nxt = S_DIV1;
      S_DIV1:  if (div_done) state_nxt = S_DIV2;
      S_DIV2:  if (div_done) state_nxt = S_OUT;
      S_OUT:   if (!ovld_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  function automatic logic [39:0] sat40(input logic [55:0] q);
    return (q[55:40] != '0) ? {40{1'b1}} : q[39:0];
  endfunction
  function automatic logic [23:0] sat24(input logic [55:0] q);
    return (q[55:24] != '0) ? {24{1'b1}} : q[23:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      warm_r  <= '0;
      offs_r  <= '0;
      used_r  <= '0;
      gfl_r   <= '0;
      gpk_r   <= '0;
      gds_r   <= '0;
      walk_r  <= '0;
      ovld_r  <= 1'b0;
      upd_r   <= 1'b0;
      alloc_seen_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      walk_r  <= walk_nxt;
      used_r  <= used_nxt;
      gfl_r   <= gfl_nxt;
      gpk_r   <= gpk_nxt;
      gds_r   <= gds_nxt;
      if (cfg_we && cfg_index == REG_WARM_UP)      warm_r <= cfg_data;
      if (cfg_we && cfg_index == REG_RESET_OFFSET) offs_r <= cfg_data;
      if (accept) upd_r <= head_probe.update;
      // Note a cell taking the new source; clear at the start of each item.
      if (|alloc_v) alloc_seen_r <= 1'b1;
      else if (accept) alloc_seen_r <= 1'b0;
      // Raise the result on load, drop it once taken.
      if (state_r == S_OUT && (!ovld_r || out_ch.ready)) ovld_r <= 1'b1;
      else if (out_ch.valid && out_ch.ready) ovld_r <= 1'b0;
    end
  end

  // Capture item, entry and quotients.
  always_ff @(posedge clk) begin
    if (accept) begin
      it_r   <= in_ch.data;
      drop_r <= (in_ch.data.func == FUNC_RECORD) && warm_drop;
      dz_r   <= 1'b0;
    end
    if (state_r == S_WALK && walk_r == CNT_W'(1)) begin
      hit_r <= probe[MAX_SOURCES].found ? probe[MAX_SOURCES].hit : '0;
      if (upd_r && !probe[MAX_SOURCES].found) drop_r <= 1'b1;
    end
    if (state_r == S_DIV0 && div_done) begin
      res_r.all_mean_delay_q8 <= (gpk_r == '0) ? '0 : sat40(div_quo);
      if (gpk_r == '0) dz_r <= 1'b1;
    end
    if (state_r == S_DIV1 && div_done) begin
      res_r.mean_delay_q8 <= (hit_r.packets == '0) ? '0 : sat40(div_quo);
      if (hit_r.valid && hit_r.packets == '0) dz_r <= 1'b1;
    end
    if (state_r == S_DIV2 && div_done) begin
      res_r.rate_q16 <= (hit_r.last_arrival == '0) ? '0 : sat24(div_quo);
      if (hit_r.valid && hit_r.last_arrival == '0) dz_r <= 1'b1;
    end
    if (state_r == S_OUT && (!ovld_r || out_ch.ready)) begin
      res_r.entry_hit    <= hit_r.valid;
      res_r.dropped      <= drop_r;
      res_r.flit_count   <= hit_r.flits;
      res_r.packet_count <= hit_r.packets;
      res_r.delay_total  <= hit_r.delay_sum;
      res_r.all_flits    <= gfl_r;
      res_r.all_packets  <= gpk_r;
      res_r.sources_seen <= 7'(used_r);
      res_r.div_by_zero  <= dz_r;
      if (!hit_r.valid) begin
        res_r.mean_delay_q8 <= '0;
        res_r.rate_q16      <= '0;
      end
    end
  end

  assign out_ch.valid = ovld_r;
  assign out_ch.data  = res_r;
endmodule

@@ bench/per_source_traffic_stats_test.sv @@
// Testbench for the per-source traffic monitor: directed rows, then random flit traffic.
// Depends on psts_pkg and psts_if; predicts every result and checks it field by field.
module per_source_traffic_stats_test;
  timeunit 1ns;
  timeprecision 1ps;
  import psts_pkg::*;

  typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    in_item_t              it;
    out_item_t             want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  bit calm = 1'b0;
  int errors = 0;

  psts_if #(.T(in_item_t))  in_ch (clk);
  psts_if #(.T(out_item_t)) out_ch (clk);

  per_source_traffic_stats uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Predicted monitor state
  logic [9:0]  tab_src [MAX_SOURCES];
  bit          tab_on [MAX_SOURCES];
  logic [31:0] tab_flits [MAX_SOURCES];
  logic [31:0] tab_pkts [MAX_SOURCES];
  logic [47:0] tab_dsum [MAX_SOURCES];
  logic [31:0] tab_last [MAX_SOURCES];
  int          tab_used = 0;
  logic [31:0] sum_flits = '0;
  logic [31:0] sum_pkts = '0;
  logic [47:0] sum_delay = '0;
  logic [31:0] warm_win = '0;
  logic [31:0] start_cycle = '0;

  out_item_t pending_results[$];

  initial begin
    for (int i = 0; i < MAX_SOURCES; i++) begin
      tab_src[i] = '0; tab_on[i] = 1'b0; tab_flits[i] = '0;
      tab_pkts[i] = '0; tab_dsum[i] = '0; tab_last[i] = '0;
    end
  end

  // floor((num << sh) / den) clipped to cap; zero divisor gives 0 and raises zero
  function automatic logic [63:0] scaled_quot(input logic [63:0] num, input int sh,
                                              input logic [63:0] den, input logic [63:0] cap,
                                              inout bit zero);
    logic [63:0] q;
    if (den == 0) begin
      zero = 1'b1;
      return '0;
    end
    q = (num << sh) / den;
    return (q > cap) ? cap : q;
  endfunction

  function automatic logic [31:0] bump32(input logic [31:0] v);
    return (v == SAT32) ? v : v + 32'd1;
  endfunction

  function automatic logic [47:0] grow48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[48] ? SAT48 : s[47:0];
  endfunction

  // Apply one item to the predicted state and return the figures it reports
  function automatic out_item_t traffic_figures(input in_item_t it);
    out_item_t r;
    int e;
    longint since;
    logic [31:0] d;
    bit dz;
    r = '0;
    e = -1;
    dz = 1'b0;
    for (int i = 0; i < MAX_SOURCES; i++)
      if (e < 0 && tab_on[i] && tab_src[i] == it.source_node) e = i;
    if (it.func == FUNC_RECORD) begin
      since = longint'({32'd0, it.arrival_cycle}) - longint'({32'd0, start_cycle});
      if (since < longint'({32'd0, warm_win})) begin
        r.dropped = 1'b1;
      end else begin
        if (e < 0 && tab_used < MAX_SOURCES) begin
          e = tab_used;
          tab_src[e] = it.source_node; tab_on[e] = 1'b1; tab_flits[e] = '0;
          tab_pkts[e] = '0; tab_dsum[e] = '0; tab_last[e] = '0;
          tab_used++;
        end
        if (e < 0) begin
          r.dropped = 1'b1;
        end else begin
          if (it.is_head) begin
            d = (it.arrival_cycle >= it.send_stamp) ? it.arrival_cycle - it.send_stamp : '0;
            tab_dsum[e] = grow48(tab_dsum[e], d);
            tab_pkts[e] = bump32(tab_pkts[e]);
            sum_delay = grow48(sum_delay, d);
            sum_pkts = bump32(sum_pkts);
          end
          tab_flits[e] = bump32(tab_flits[e]);
          sum_flits = bump32(sum_flits);
          tab_last[e] = it.arrival_cycle - warm_win;
        end
      end
    end
    if (e >= 0) begin
      r.entry_hit = 1'b1;
      r.flit_count = tab_flits[e];
      r.packet_count = tab_pkts[e];
      r.delay_total = tab_dsum[e];
      r.mean_delay_q8 = 40'(scaled_quot(64'(tab_dsum[e]), 8, 64'(tab_pkts[e]),
                                        64'hFF_FFFF_FFFF, dz));
      r.rate_q16 = 24'(scaled_quot(64'(tab_flits[e]), 16, 64'(tab_last[e]),
                                   64'hFF_FFFF, dz));
    end
    r.all_flits = sum_flits;
    r.all_packets = sum_pkts;
    r.sources_seen = tab_used[6:0];
    r.all_mean_delay_q8 = 40'(scaled_quot(64'(sum_delay), 8, 64'(sum_pkts),
                                          64'hFF_FFFF_FFFF, dz));
    r.div_by_zero = dz;
    return r;
  endfunction

  // Drive the result side's ready
  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    out_item_t w;
    out_item_t g;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      g = out_ch.data;
      if (pending_results.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        w = pending_results.pop_front();
        check_field("entry_hit", 64'(w.entry_hit), 64'(g.entry_hit));
        check_field("dropped", 64'(w.dropped), 64'(g.dropped));
        check_field("flit_count", 64'(w.flit_count), 64'(g.flit_count));
        check_field("packet_count", 64'(w.packet_count), 64'(g.packet_count));
        check_field("delay_total", 64'(w.delay_total), 64'(g.delay_total));
        check_field("mean_delay_q8", 64'(w.mean_delay_q8), 64'(g.mean_delay_q8));
        check_field("rate_q16", 64'(w.rate_q16), 64'(g.rate_q16));
        check_field("all_flits", 64'(w.all_flits), 64'(g.all_flits));
        check_field("all_packets", 64'(w.all_packets), 64'(g.all_packets));
        check_field("sources_seen", 64'(w.sources_seen), 64'(g.sources_seen));
        check_field("all_mean_delay_q8", 64'(w.all_mean_delay_q8),
                    64'(g.all_mean_delay_q8));
        check_field("div_by_zero", 64'(w.div_by_zero), 64'(g.div_by_zero));
      end
    end
  end

  // Offer one item, hold it until accepted, then queue its prediction
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t p;
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    p = traffic_figures(it);
    pending_results.insert(pending_results.size(), typed ? want : p);
  endtask

  // Drain the block, then write one register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_ch.valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WARM_UP) warm_win = val;
    else start_cycle = val;
  endtask

  function automatic row_t flit_row(input logic func, input logic [31:0] arr,
                                    input logic [9:0] src, input logic head,
                                    input logic [31:0] stamp);
    row_t r;
    r.kind = ROW_ITEM;
    r.it.func = func;
    r.it.arrival_cycle = arr;
    r.it.source_node = src;
    r.it.is_head = head;
    r.it.send_stamp = stamp;
    r.want = '0;
    r.idx = '0;
    r.val = '0;
    return r;
  endfunction

  function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    row_t r;
    r = flit_row(FUNC_QUERY, '0, '0, 1'b0, '0);
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic in_item_t random_flit();
    in_item_t it;
    logic [31:0] floor_cycle;
    floor_cycle = start_cycle + warm_win;
    it.func = ($urandom_range(0, 99) < 15) ? FUNC_QUERY : FUNC_RECORD;
    it.source_node = ($urandom_range(0, 99) < 15) ? 10'($urandom_range(0, 1023))
                                                 : 10'($urandom_range(0, 39) * 25);
    it.arrival_cycle = ($urandom_range(0, 99) < 80) ? floor_cycle + $urandom_range(0, 100000)
                                                    : $urandom();
    it.is_head = 1'($urandom_range(0, 1));
    it.send_stamp = ($urandom_range(0, 99) < 80) ? it.arrival_cycle - $urandom_range(0, 500)
                                                 : $urandom();
    return it;
  endfunction

  row_t plan[$];

  // Append one row to the stimulus table
  function automatic void add_row(input row_t r);
    plan.insert(plan.size(), r);
  endfunction

  initial begin
    row_t r;
    out_item_t none;
    none = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows: warm-up window, extremes, negative delay, zero divisors
    r = flit_row(FUNC_QUERY, '0, 10'd7, 1'b0, '0);
    r.kind = ROW_TYPED; r.want = '0; r.want.div_by_zero = 1'b1;
    add_row(r);
    add_row(reg_row(REG_WARM_UP, 32'd100));
    add_row(reg_row(REG_RESET_OFFSET, 32'd1000));
    r = flit_row(FUNC_RECORD, 32'd1099, 10'd3, 1'b1, 32'd0);
    r.kind = ROW_TYPED; r.want = '0; r.want.dropped = 1'b1; r.want.div_by_zero = 1'b1;
    add_row(r);
    r = flit_row(FUNC_RECORD, 32'd1100, 10'd1023, 1'b1, 32'd1000);
    r.kind = ROW_TYPED; r.want = '0;
    r.want.entry_hit = 1'b1; r.want.flit_count = 32'd1; r.want.packet_count = 32'd1;
    r.want.delay_total = 48'd100; r.want.mean_delay_q8 = 40'd25600; r.want.rate_q16 = 24'd65;
    r.want.all_flits = 32'd1; r.want.all_packets = 32'd1; r.want.sources_seen = 7'd1;
    r.want.all_mean_delay_q8 = 40'd25600;
    add_row(r);
    add_row(flit_row(FUNC_RECORD, 32'd5000, 10'd1023, 1'b0, 32'd0));
    add_row(flit_row(FUNC_RECORD, 32'd2000, 10'd5, 1'b1, 32'hFFFF_FFFF));
    add_row(flit_row(FUNC_QUERY, 32'd0, 10'd5, 1'b0, 32'd0));
    add_row(flit_row(FUNC_QUERY, 32'hFFFF_FFFF, 10'd6, 1'b1, 32'hFFFF_FFFF));
    add_row(flit_row(FUNC_RECORD, 32'hFFFF_FFFF, 10'd0, 1'b1, 32'd0));
    add_row(flit_row(FUNC_RECORD, 32'hFFFF_FFFF, 10'd0, 1'b1, 32'd0));
    add_row(reg_row(REG_WARM_UP, 32'd0));
    add_row(reg_row(REG_RESET_OFFSET, 32'd0));
    add_row(flit_row(FUNC_RECORD, 32'd0, 10'd9, 1'b1, 32'd0));
    add_row(flit_row(FUNC_QUERY, 32'd0, 10'd9, 1'b0, 32'd0));
    add_row(reg_row(REG_WARM_UP, 32'hFFFF_FFFF));
    add_row(flit_row(FUNC_RECORD, 32'hFFFF_FFFE, 10'd9, 1'b0, 32'd0));
    add_row(flit_row(FUNC_RECORD, 32'hFFFF_FFFF, 10'd9, 1'b0, 32'd0));
    add_row(reg_row(REG_WARM_UP, 32'd0));
    add_row(reg_row(REG_RESET_OFFSET, 32'hFFFF_FFFF));
    add_row(flit_row(FUNC_RECORD, 32'd5, 10'd512, 1'b1, 32'd0));
    add_row(flit_row(FUNC_RECORD, 32'hFFFF_FFFF, 10'd512, 1'b1, 32'h0000_0100));
    add_row(flit_row(FUNC_QUERY, 32'd0, 10'd0, 1'b0, 32'd0));

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].idx, plan[i].val);
      else send_item(plan[i].it, plan[i].kind == ROW_TYPED, plan[i].want);
    end

    // Random traffic in four register settings; one stretch runs without idling
    for (int seg = 0; seg < 4; seg++) begin
      case (seg)
        0: begin
          write_reg(REG_WARM_UP, 32'd0);
          write_reg(REG_RESET_OFFSET, 32'd0);
        end
        1: begin
          write_reg(REG_WARM_UP, $urandom_range(0, 2000));
          write_reg(REG_RESET_OFFSET, $urandom_range(0, 1000000));
        end
        2: begin
          write_reg(REG_WARM_UP, $urandom());
          write_reg(REG_RESET_OFFSET, $urandom());
        end
        default: begin
          write_reg(REG_WARM_UP, $urandom_range(0, 50));
          write_reg(REG_RESET_OFFSET, 32'd0);
        end
      endcase
      for (int n = 0; n < 200; n++) begin
        calm = (seg == 0 && n >= 100);
        send_item(random_flit(), 1'b0, none);
      end
      calm = 1'b0;
    end
    in_ch.valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (300) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("per_source_traffic_stats_test: done, clean");
    end else begin
      $display("per_source_traffic_stats_test: done, errors");
    end
    $finish;
  end

  // Hard stop for a hung handshake
  initial begin
    #20ms;
    $display("per_source_traffic_stats_test: done, errors");
    $finish;
  end

endmodule
